/* rtl/core/gate_command_encoder_top_defines.svh */
// Assertion macros for the checker file.
`ifndef GATE_COMMAND_ENCODER_TOP_DEFINES_SVH
`define GATE_COMMAND_ENCODER_TOP_DEFINES_SVH

// Assert that an antecedent implies a consequent in the cycle after it.
`define GCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define GCE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/core/gce_pkg.sv */
// Package with shared types, constants and the arctangent table.
`timescale 1ns / 1ps
package gce_pkg;

  localparam int unsigned GateSlots   = 32768;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned SlotW       = 15;
  localparam int unsigned DataW       = 34;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = 2;

  localparam logic [22:0] PiQ20   = 23'd3294199;
  localparam logic [DataW-1:0] GainQ30 = 34'h026DD3B6A;
  localparam logic [4:0] QubitCountReset = 5'd3;

  localparam logic [2:0] OpH    = 3'd0;
  localparam logic [2:0] OpS    = 3'd1;
  localparam logic [2:0] OpCnot = 3'd2;
  localparam logic [2:0] OpRz   = 3'd5;

  // Classified gate handed from front to back.
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [26:0]      word;
    logic [2:0]       code;
    logic             rot;
    logic [DataW-1:0] z;
  } front_item_t;

  // CORDIC stage payload.
  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [26:0]      word;
    logic [2:0]       code;
    logic             rot;
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
  } cordic_item_t;

  function automatic logic [DataW-1:0] atan_q30(input int unsigned i);
    logic [31:0] t;
    case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD; 10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
      27: t = 32'h00000007;
      default: t = 32'h0;
    endcase
    return {2'b00, t};
  endfunction

  // Q.30 to Q1.22 with truncation toward zero and saturation to +-1.
  function automatic logic [23:0] to_q22(input logic [DataW-1:0] v);
    logic [DataW-1:0] mag;
    logic [DataW-1:0] q;
    mag = v[DataW-1] ? (~v + 1'b1) : v;
    q = mag >> 8;
    if (q > 34'd4194304) begin
      q = 34'd4194304;
    end
    if (v[DataW-1]) begin
      q = ~q + 1'b1;
    end
    return q[23:0];
  endfunction

endpackage

/* rtl/core/gce_if.sv */
// Valid/ready channel interfaces for gate requests and command records.
`timescale 1ns / 1ps
interface gce_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [4:0]  target_qubit;
  logic [4:0]  control_qubit;
  logic signed [22:0] angle;
  logic        restart_slot;
  modport source (output valid, operation, target_qubit, control_qubit, angle,
                  restart_slot, input ready);
  modport sink (input valid, operation, target_qubit, control_qubit, angle,
                restart_slot, output ready);
endinterface

interface gce_cmd_if;
  logic        valid;
  logic        ready;
  logic [14:0] slot_index;
  logic [26:0] qubit_word;
  logic [23:0] cos_word;
  logic [23:0] sin_word;
  logic [2:0]  gate_code;
  modport source (output valid, slot_index, qubit_word, cos_word, sin_word, gate_code,
                  input ready);
  modport sink (input valid, slot_index, qubit_word, cos_word, sin_word, gate_code,
                output ready);
endinterface

/* rtl/core/gate_command_encoder_top.sv */
// Top level of the gate command encoder.
//   channel | dir | handshake      | content
//   req     | in  | valid/ready    | gate request
//   cmd     | out | valid/ready    | command record
//   cfg     | in  | cfg_we_i       | qubit_count
// One beat per cycle while cmd does not stall; a beat is held in the queue and then in each
// CORDIC stage in turn, the last of the 24 stages driving cmd.
// The front takes a beat whenever the 4-entry queue has room.
// Reset clears the slot counter, queue and stage valids; qubit_count resets to 3.
// A stall on cmd freezes the CORDIC pipe, then fills the queue, then drops req.ready.
`timescale 1ns / 1ps
module gate_command_encoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  gce_req_if.sink     req,
  gce_cmd_if.source   cmd
);

  logic [4:0] qubit_count_q;
  gce_pkg::front_item_t f_item, q_item;
  logic full, empty, fire, pop, back_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qubit_count_q <= gce_pkg::QubitCountReset;
    end else if (cfg_we_i) begin
      qubit_count_q <= cfg_wdata_i;
    end
  end

  assign req.ready = !full;
  assign fire      = req.valid && !full;
  assign pop       = !empty && back_ready;

  gce_front u_front (
    .clk_i, .rst_ni, .fire_i(fire),
    .operation_i(req.operation), .target_qubit_i(req.target_qubit),
    .control_qubit_i(req.control_qubit), .angle_i(req.angle),
    .restart_slot_i(req.restart_slot), .qubit_count_i(qubit_count_q),
    .item_o(f_item)
  );

  gce_queue u_queue (
    .clk_i, .rst_ni, .push_i(fire), .push_data_i(f_item), .full_o(full),
    .pop_i(pop), .empty_o(empty), .pop_data_o(q_item)
  );

  gce_back u_back (
    .clk_i, .rst_ni, .in_valid_i(!empty), .in_ready_o(back_ready),
    .in_data_i(q_item), .cmd(cmd)
  );

endmodule

/* rtl/core/gce_front.sv */
// Front end: slot assignment, cut computation and gate classification.
`timescale 1ns / 1ps
module gce_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [2:0]              operation_i,
  input  logic [4:0]              target_qubit_i,
  input  logic [4:0]              control_qubit_i,
  input  logic [22:0]             angle_i,
  input  logic                    restart_slot_i,
  input  logic [4:0]              qubit_count_i,
  output gce_pkg::front_item_t    item_o
);

  logic [gce_pkg::SlotW-1:0] slot_q, slot_d, slot_cur;
  logic [4:0]  expo;
  logic [16:0] cut;
  logic [22:0] ang;
  logic        valid_op;

  // Slot counter with restart and wrap.
  always_comb begin
    slot_cur = restart_slot_i ? '0 : slot_q;
    if ({1'b0, slot_cur} + 16'd1 >= 16'(gce_pkg::GateSlots)) begin
      slot_d = '0;
    end else begin
      slot_d = slot_cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (fire_i) begin
      slot_q <= slot_d;
    end
  end

  // Cut and packed word.
  always_comb begin
    expo = qubit_count_i - target_qubit_i - 5'd1;
    cut = '0;
    if (target_qubit_i < qubit_count_i && expo <= 5'd16) begin
      cut = 17'd1 << expo;
    end
    valid_op = (operation_i <= gce_pkg::OpRz);
    item_o.slot = slot_cur;
    item_o.word = '0;
    item_o.code = '0;
    if (valid_op) begin
      item_o.word[21:17] = target_qubit_i;
      if (operation_i != gce_pkg::OpS) begin
        item_o.word[16:0] = cut;
      end
      if (operation_i == gce_pkg::OpCnot) begin
        item_o.word[26:22] = control_qubit_i;
      end
      item_o.code = operation_i + 3'd1;
    end
    item_o.rot = valid_op && operation_i > gce_pkg::OpCnot;
    // Clamp to +-pi, then the Q3.20 value is taken as Q.21 half angle in Q.30.
    ang = angle_i;
    if ($signed(ang) > $signed(gce_pkg::PiQ20)) begin
      ang = gce_pkg::PiQ20;
    end
    if ($signed(ang) < -$signed(gce_pkg::PiQ20)) begin
      ang = -gce_pkg::PiQ20;
    end
    item_o.z = {{2{ang[22]}}, ang, 9'd0};
  end

endmodule

/* rtl/core/gce_queue.sv */
// Short FIFO between the front and back ends.
`timescale 1ns / 1ps
module gce_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  gce_pkg::front_item_t push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output gce_pkg::front_item_t pop_data_o
);

  gce_pkg::front_item_t mem_q [gce_pkg::QueueDepth];
  logic [gce_pkg::QueuePtrW-1:0] wr_q, rd_q;
  logic [gce_pkg::QueuePtrW:0]   cnt_q;

  assign full_o     = (cnt_q == 3'(gce_pkg::QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // Storage is payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + {2'b00, push_i} - {2'b00, pop_i};
    end
  end

endmodule

/* rtl/core/gce_back.sv */
// Back end: pipelined CORDIC, one iteration per stage; the last stage drives the outputs.
`timescale 1ns / 1ps
module gce_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gce_pkg::front_item_t in_data_i,
  gce_cmd_if.source            cmd
);

  localparam int unsigned N = gce_pkg::CordicSteps;

  gce_pkg::cordic_item_t st_q [N+1];
  logic [N:1] vld_q;
  logic       adv;

  // The whole pipe moves together whenever the last stage can drain.
  assign adv        = !vld_q[N] || cmd.ready;
  assign in_ready_o = adv;

  always_comb begin
    st_q[0].slot = in_data_i.slot;
    st_q[0].word = in_data_i.word;
    st_q[0].code = in_data_i.code;
    st_q[0].rot  = in_data_i.rot;
    st_q[0].x    = gce_pkg::GainQ30;
    st_q[0].y    = '0;
    st_q[0].z    = in_data_i.z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[N-1:1], in_valid_i};
    end
  end

  // One rotation per stage.
  for (genvar i = 0; i < N; i++) begin : g_stage
    gce_pkg::cordic_item_t nx;
    logic signed [gce_pkg::DataW-1:0] dx, dy;
    always_comb begin
      // Arithmetic shifts round toward minus infinity.
      dx = $signed(st_q[i].y) >>> i;
      dy = $signed(st_q[i].x) >>> i;
      nx = st_q[i];
      if (!st_q[i].z[gce_pkg::DataW-1]) begin
        nx.x = st_q[i].x - dx;
        nx.y = st_q[i].y + dy;
        nx.z = st_q[i].z - gce_pkg::atan_q30(i);
      end else begin
        nx.x = st_q[i].x + dx;
        nx.y = st_q[i].y - dy;
        nx.z = st_q[i].z + gce_pkg::atan_q30(i);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[i+1] <= nx;
      end
    end
  end

  // Output formatting.
  assign cmd.valid      = vld_q[N];
  assign cmd.slot_index = st_q[N].slot;
  assign cmd.qubit_word = st_q[N].word;
  assign cmd.gate_code  = st_q[N].code;
  assign cmd.cos_word   = st_q[N].rot ? gce_pkg::to_q22(st_q[N].x) : '0;
  assign cmd.sin_word   = st_q[N].rot ? gce_pkg::to_q22(st_q[N].y) : '0;

endmodule

/* rtl/core/gce_checker.sv */
// Port-level checker for the gate command encoder, bound to the top level.
`timescale 1ns / 1ps
`include "gate_command_encoder_top_defines.svh"
module gce_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [14:0] cmd_slot,
  input logic [26:0] cmd_word,
  input logic [23:0] cmd_cos,
  input logic [2:0]  cmd_code
);
  `GCE_ASSERT_NEXT(a_hold, clk_i, rst_ni, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd_slot), "cmd beat dropped while stalled")
  `GCE_ASSERT_NOW(a_code, clk_i, rst_ni, cmd_valid, cmd_code <= 3'd6, "bad gate code")
  `GCE_ASSERT_NOW(a_noop, clk_i, rst_ni, cmd_valid && cmd_code == 3'd0, cmd_word == '0 && cmd_cos == '0, "no-op record not empty")
  `GCE_ASSERT_NOW(a_nonrot, clk_i, rst_ni, cmd_valid && cmd_code <= 3'd3, cmd_cos == '0, "non-rotation has trig")
endmodule

bind gate_command_encoder_top gce_checker u_gce_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .cmd_slot(cmd.slot_index), .cmd_word(cmd.qubit_word), .cmd_cos(cmd.cos_word),
  .cmd_code(cmd.gate_code)
);
